// ===== sv/sid_pkg.sv =====
`default_nettype none

package sid_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;

  // clear is decoded from both mode bits and probe from the high bit alone, so the unused code acts as a probe
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd2;
  localparam int unsigned       PROBE_BIT   = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_MATCH     = 3'd4,
    ST_ABSENT    = 3'd5,
    ST_REPORTED  = 3'd6
  } status_e;

  // xor fold of the value down to a slot index, brought into range
  function automatic logic [IDX_W-1:0] hash_idx(input logic [VALUE_W-1:0] v);
    logic [IDX_W-1:0] f;
    f = '0;
    for (int i = 0; i < VALUE_W; i += IDX_W) begin
      f = f ^ IDX_W'(v >> i);
    end
    if ({1'b0, f} >= (IDX_W + 1)'(ENTRIES)) begin
      f = f - IDX_W'(ENTRIES);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== sv/set_intersection_distinct_core.sv =====
// A clear goes from idle straight to the result state; an insert or probe walks the linear
// probe through the look and compare states until an empty slot, a hit or every slot (k
// occupied slots examined, 0 to the table size; each is one read and one compare). No new
// word is taken until the result moves to the output register, after any wait for m_axis_tready.
// Reset clears the slot valid marks, reported marks and fill count at once; the value
// memory is not initialised and no clearing pass runs.
`default_nettype none

module set_intersection_distinct_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] value_out
  output logic [2:0]       m_axis_tuser    // [2:0] status
);

  localparam int unsigned IDX_W = sid_pkg::IDX_W;
  localparam int unsigned CNT_W = sid_pkg::CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(sid_pkg::ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [sid_pkg::ENTRIES-1:0]   valid_q;
  logic [sid_pkg::ENTRIES-1:0]   rep_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          out_valid_q;

  logic                          probe_q;
  logic [sid_pkg::VALUE_W-1:0]   val_q;
  logic [IDX_W-1:0]              idx_q;
  logic [IDX_W-1:0]              scan_q;
  sid_pkg::status_e              status_q, status_d;
  sid_pkg::status_e              out_status_q;
  logic [sid_pkg::VALUE_W-1:0]   out_value_q;

  logic [sid_pkg::VALUE_W-1:0]   mem_q [sid_pkg::ENTRIES];
  logic [sid_pkg::VALUE_W-1:0]   rd_q;

  logic             s_fire;
  logic             in_clear;
  logic             out_free;
  logic             slot_full;
  logic             cmp_match;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] idx_next;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_clear      = (s_axis_tuser == sid_pkg::MODE_CLEAR);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign slot_full     = valid_q[idx_q];
  assign cmp_match     = (rd_q == val_q);
  assign mem_we        = (state_q == S_LOOK) && !slot_full && !probe_q;
  assign mem_re        = (state_q == S_LOOK) && slot_full;
  assign idx_next      = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d  = in_clear ? S_RES : S_LOOK;
          status_d = sid_pkg::ST_CLEARED;
        end
      end
      S_LOOK: begin
        if (slot_full) begin
          state_d = S_CMP;
        end else begin
          // empty slot ends the probe chain: value is absent
          state_d = S_RES;
          if (probe_q) begin
            status_d = sid_pkg::ST_ABSENT;
          end else begin
            status_d = sid_pkg::ST_INSERTED;
          end
        end
      end
      S_CMP: begin
        if (cmp_match) begin
          state_d = S_RES;
          if (!probe_q) begin
            status_d = sid_pkg::ST_DUPLICATE;
          end else if (rep_q[idx_q]) begin
            status_d = sid_pkg::ST_REPORTED;
          end else begin
            status_d = sid_pkg::ST_MATCH;
          end
        end else if (scan_q == LAST_IDX) begin
          // every slot taken and none holds the value
          state_d = S_RES;
          if (probe_q) begin
            status_d = sid_pkg::ST_ABSENT;
          end else begin
            status_d = sid_pkg::ST_FULL;
          end
        end else begin
          state_d = S_LOOK;
        end
      end
      S_RES: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rep_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_fire && in_clear) begin
        valid_q <= '0;
        rep_q   <= '0;
        cnt_q   <= '0;
      end
      if (mem_we) begin
        valid_q[idx_q] <= 1'b1;
        rep_q[idx_q]   <= 1'b0;
        cnt_q          <= cnt_q + 1'b1;
      end
      if ((state_q == S_CMP) && cmp_match && probe_q) begin
        rep_q[idx_q] <= 1'b1;
      end
      if ((state_q == S_RES) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (s_fire) begin
      val_q   <= s_axis_tdata;
      probe_q <= s_axis_tuser[sid_pkg::PROBE_BIT];
      idx_q   <= sid_pkg::hash_idx(s_axis_tdata);
      scan_q  <= '0;
    end else if ((state_q == S_CMP) && !cmp_match) begin
      idx_q  <= idx_next;
      scan_q <= scan_q + 1'b1;
    end
    if ((state_q == S_RES) && out_free) begin
      out_status_q <= status_q;
      out_value_q  <= val_q;
    end
  end

  // value table: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= val_q;
    end
    if (mem_re) begin
      rd_q <= mem_q[idx_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(sid_pkg::ENTRIES))
    else $error("fill count beyond table size");

  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("fill count disagrees with valid marks");

  a_cmp_on_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> valid_q[idx_q])
    else $error("compare on an empty slot");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_clear) |=> (valid_q == '0) && (rep_q == '0) && (cnt_q == '0))
    else $error("clear left table contents");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RES) && out_free) |=> (m_axis_tvalid && (state_q == S_IDLE)))
    else $error("result not presented");

endmodule

`default_nettype wire
